/* rtl/core/cdt_pkg.sv */
// Shared constants and types for the countdown timer with keys.
// Holds field widths, register map, reset values and digit-split constants.
// No dependencies.
`default_nettype none

package cdt_pkg;

  localparam int CountW  = 13;
  localparam int TpsW    = 4;
  localparam int DebW    = 2;
  localparam int KeyW    = 3;
  localparam int PaddrW  = 4;
  localparam int PdataW  = 32;
  localparam int RegIdxW = 2;

  // Register map, word index = paddr[3:2]
  localparam logic [RegIdxW-1:0] RegPresetShort = 2'd0;
  localparam logic [RegIdxW-1:0] RegPresetLong  = 2'd1;
  localparam logic [RegIdxW-1:0] RegTicksPerSec = 2'd2;
  localparam logic [RegIdxW-1:0] RegDebounce    = 2'd3;

  localparam logic [CountW-1:0] PresetShortRst = 13'd300;
  localparam logic [CountW-1:0] PresetLongRst  = 13'd900;
  localparam logic [TpsW-1:0]   TicksPerSecRst = 4'd4;
  localparam logic [DebW-1:0]   DebounceRst    = 2'd2;

  // Item kinds
  localparam logic ReqTick = 1'b0;
  localparam logic ReqKeys = 1'b1;

  // Key bit positions
  localparam int KeyReset = 0;
  localparam int KeyStop  = 1;
  localparam int KeyStart = 2;

  // Reciprocals scaled by 2**RecipShift, rounded up; exact over 13-bit counts
  localparam int RecipShift = 24;
  localparam logic [14:0] Recip600 = 15'd27963;
  localparam logic [18:0] Recip60  = 19'd279621;
  localparam logic [20:0] Recip10  = 21'd1677722;

  typedef struct packed {
    logic running;
    logic colon_on;
    logic alarm;
    logic long_selected;
  } cdt_flags_t;

endpackage

`default_nettype wire

/* rtl/core/countdown_timer_with_keys_top.sv */
// Countdown timer with debounced keys, top level.
// Depends on cdt_pkg for widths, register map and digit constants.
//
// Usage:
//   Input channel (in_valid, in_stall, req_type, keys): each transfer is one
//   timebase tick (req_type 0) or one sample of the three keys (req_type 1).
//   Output channel (out_valid, out_stall, remaining, digits, flags): one
//   transfer per input item, showing the timer state after that item.
//   Configuration over the APB port: preset_short at 0x0, preset_long at 0x4,
//   ticks_per_second at 0x8, debounce_ticks at 0xC; write only while idle.
// Timing:
//   The timer state updates at the edge that takes the item, which also loads
//   snapshot register a; the result then goes through reciprocal-multiply
//   stage b and digit stage c. One item per cycle is taken while out_stall
//   stays low; the three pipeline registers are stages a, b and c.
// Reset (rst, synchronous): registers return to their defaults, the count
//   loads 300, the colon is lit and the output channel empties.
// Stall: a stalled result holds in the output register; items keep entering
//   until all three stages are full, then in_stall rises.
`default_nettype none

module countdown_timer_with_keys_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // APB configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cdt_pkg::PaddrW-1:0]  paddr,
  input  wire logic [cdt_pkg::PdataW-1:0]  pwdata,
  output logic      [cdt_pkg::PdataW-1:0]  prdata,
  output logic                             pready,
  // input items
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        req_type,
  input  wire logic [cdt_pkg::KeyW-1:0]    keys,
  // results
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [cdt_pkg::CountW-1:0]  remaining,
  output logic      [3:0]                  min_tens,
  output logic      [3:0]                  min_units,
  output logic      [2:0]                  sec_tens,
  output logic      [3:0]                  sec_units,
  output logic                             running,
  output logic                             colon_on,
  output logic                             alarm,
  output logic                             long_selected
);
  import cdt_pkg::*;

  // configuration registers
  logic [CountW-1:0] preset_short;
  logic [CountW-1:0] preset_long;
  logic [TpsW-1:0]   ticks_per_second;
  logic [DebW-1:0]   debounce_ticks;

  // timer state
  logic [CountW-1:0] count_left,     count_left_next;
  logic              use_long,       use_long_next;
  logic              run_flag,       run_flag_next;
  logic              alarm_flag,     alarm_flag_next;
  logic              colon_flag,     colon_flag_next;
  logic [TpsW-1:0]   tick_phase,     tick_phase_next;
  logic [DebW-1:0]   debounce_count, debounce_count_next;
  logic [KeyW-1:0]   last_keys,      last_keys_next;
  logic              key_held,       key_held_next;

  logic [TpsW-1:0]   phase_inc;
  logic [CountW-1:0] preset_cur;
  logic [CountW-1:0] preset_other;

  // pipeline
  logic              accept;
  logic              a_valid, b_valid, c_valid;
  logic              a_load, b_load, c_load;
  logic [CountW-1:0] a_count, b_count;
  cdt_flags_t        a_flags, b_flags, c_flags;
  logic [3:0]        b_q600;
  logic [7:0]        b_q60;
  logic [9:0]        b_q10;
  logic [27:0]       prod600;
  logic [31:0]       prod60;
  logic [33:0]       prod10;
  logic [7:0]        q600_x10;
  logic [9:0]        q60_x6;
  logic [13:0]       q10_x10;
  logic              cfg_write;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[PaddrW-1:2])
      RegPresetShort: prdata = PdataW'(preset_short);
      RegPresetLong:  prdata = PdataW'(preset_long);
      RegTicksPerSec: prdata = PdataW'(ticks_per_second);
      RegDebounce:    prdata = PdataW'(debounce_ticks);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preset_short     <= PresetShortRst;
      preset_long      <= PresetLongRst;
      ticks_per_second <= TicksPerSecRst;
      debounce_ticks   <= DebounceRst;
    end else if (cfg_write) begin
      unique case (paddr[PaddrW-1:2])
        RegPresetShort: preset_short     <= pwdata[CountW-1:0];
        RegPresetLong:  preset_long      <= pwdata[CountW-1:0];
        RegTicksPerSec: ticks_per_second <= pwdata[TpsW-1:0];
        RegDebounce:    debounce_ticks   <= pwdata[DebW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  assign c_load   = !c_valid || !out_stall;
  assign b_load   = !b_valid || c_load;
  assign a_load   = !a_valid || b_load;
  assign in_stall = !a_load;
  assign accept   = in_valid && !in_stall;

  // ---------------- timer state update ----------------
  assign phase_inc    = tick_phase + TpsW'(1);
  assign preset_cur   = use_long ? preset_long : preset_short;
  assign preset_other = use_long ? preset_short : preset_long;

  always_comb begin
    count_left_next     = count_left;
    use_long_next       = use_long;
    run_flag_next       = run_flag;
    alarm_flag_next     = alarm_flag;
    colon_flag_next     = colon_flag;
    tick_phase_next     = tick_phase;
    debounce_count_next = debounce_count;
    last_keys_next      = last_keys;
    key_held_next       = key_held;

    if (accept) begin
      if (req_type == ReqTick) begin
        if (phase_inc >= ticks_per_second) begin
          tick_phase_next = '0;
          if (run_flag) begin
            if (count_left != '0) begin
              count_left_next = count_left - CountW'(1);
            end
            if (count_left_next == '0) begin
              run_flag_next   = 1'b0;
              alarm_flag_next = 1'b1;
            end
            colon_flag_next = 1'b1;
          end
        end else begin
          tick_phase_next = phase_inc;
        end
        // blank the colon at the half-second point
        if ((tick_phase_next == (ticks_per_second >> 1)) && run_flag_next) begin
          colon_flag_next = 1'b0;
        end
        if (debounce_count != '0) begin
          debounce_count_next = debounce_count - DebW'(1);
        end
      end else begin
        if (keys != last_keys) begin
          // restart debounce on any change
          debounce_count_next = debounce_ticks;
          last_keys_next      = keys;
        end else if (debounce_count == '0) begin
          if (key_held) begin
            if (keys == '0) begin
              key_held_next = 1'b0;
            end
          end else if (keys != '0) begin
            key_held_next = 1'b1;
            priority if (keys[KeyReset]) begin
              if (!run_flag) begin
                if (count_left != preset_cur) begin
                  count_left_next = preset_cur;
                  alarm_flag_next = 1'b0;
                end else begin
                  use_long_next   = !use_long;
                  count_left_next = preset_other;
                end
                if (count_left_next == '0) begin
                  alarm_flag_next = 1'b1;
                end
              end
              colon_flag_next = 1'b1;
            end else if (keys[KeyStop]) begin
              if (run_flag) begin
                run_flag_next = 1'b0;
                if (count_left == '0) begin
                  alarm_flag_next = 1'b1;
                end
              end
            end else begin
              if (!run_flag && (count_left != '0)) begin
                run_flag_next = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_left     <= PresetShortRst;
      use_long       <= 1'b0;
      run_flag       <= 1'b0;
      alarm_flag     <= 1'b0;
      colon_flag     <= 1'b1;
      tick_phase     <= '0;
      debounce_count <= '0;
      last_keys      <= '0;
      key_held       <= 1'b0;
    end else begin
      count_left     <= count_left_next;
      use_long       <= use_long_next;
      run_flag       <= run_flag_next;
      alarm_flag     <= alarm_flag_next;
      colon_flag     <= colon_flag_next;
      tick_phase     <= tick_phase_next;
      debounce_count <= debounce_count_next;
      last_keys      <= last_keys_next;
      key_held       <= key_held_next;
    end
  end

  // ---------------- stage a: snapshot of the new state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_count               <= count_left_next;
      a_flags.running       <= run_flag_next;
      a_flags.colon_on      <= colon_flag_next;
      a_flags.alarm         <= alarm_flag_next;
      a_flags.long_selected <= use_long_next;
    end
  end

  // ---------------- stage b: quotients by reciprocal multiply ----------------
  assign prod600 = 28'(a_count) * 28'(Recip600);
  assign prod60  = 32'(a_count) * 32'(Recip60);
  assign prod10  = 34'(a_count) * 34'(Recip10);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load && a_valid) begin
      b_count <= a_count;
      b_flags <= a_flags;
      b_q600  <= prod600[RecipShift+3:RecipShift];
      b_q60   <= prod60[RecipShift+7:RecipShift];
      b_q10   <= prod10[RecipShift+9:RecipShift];
    end
  end

  // ---------------- stage c: digits, output register ----------------
  assign q600_x10 = 8'(b_q600) * 8'd10;
  assign q60_x6   = 10'(b_q60) * 10'd6;
  assign q10_x10  = 14'(b_q10) * 14'd10;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_load) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load && b_valid) begin
      remaining <= b_count;
      min_tens  <= b_q600;
      min_units <= 4'(b_q60 - q600_x10);
      sec_tens  <= 3'(b_q10 - q60_x6);
      sec_units <= 4'(14'(b_count) - q10_x10);
      c_flags   <= b_flags;
    end
  end

  assign out_valid     = c_valid;
  assign running       = c_flags.running;
  assign colon_on      = c_flags.colon_on;
  assign alarm         = c_flags.alarm;
  assign long_selected = c_flags.long_selected;

  // ---------------- assertions ----------------
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    run_flag |-> (count_left != '0))
    else $error("timer running at zero count");

  a_digits_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((min_units <= 4'd9) && (sec_tens <= 3'd5) && (sec_units <= 4'd9)))
    else $error("digit out of range");

  a_digits_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (16'(remaining) ==
      16'(min_tens) * 16'd600 + 16'(min_units) * 16'd60 +
      16'(sec_tens) * 16'd10 + 16'(sec_units)))
    else $error("digits do not add up to remaining");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (a_valid && b_valid && c_valid && out_stall) |-> in_stall)
    else $error("item taken into a full pipeline");

endmodule

`default_nettype wire

/* dv/countdown_timer_with_keys_top_test.sv */
// Self-checking bench for countdown_timer_with_keys_top: sends ticks and key samples,
// predicts readouts with a local timer model or fixed values and checks the result channel.
// Depends on cdt_pkg and the countdown_timer_with_keys_top RTL.

module countdown_timer_with_keys_top_test;
  import cdt_pkg::*;

  typedef struct packed {
    logic [CountW-1:0] remaining;
    logic [3:0]        min_tens;
    logic [3:0]        min_units;
    logic [2:0]        sec_tens;
    logic [3:0]        sec_units;
    logic              running;
    logic              colon_on;
    logic              alarm;
    logic              long_selected;
  } readout_t;

  typedef struct packed {
    logic               is_write;
    logic               kind;
    logic [KeyW-1:0]    pressed;
    logic [RegIdxW-1:0] idx;
    logic [PdataW-1:0]  val;
    logic               typed;
    readout_t           want;
  } step_t;

  typedef struct packed {
    logic [CountW-1:0] short_preset;
    logic [CountW-1:0] long_preset;
    logic [TpsW-1:0]   tick_rate;
    logic [DebW-1:0]   debounce;
  } timer_cfg_t;

  localparam logic [KeyW-1:0] KeysNone   = '0;
  localparam logic [KeyW-1:0] PressReset = KeyW'(1 << KeyReset);
  localparam logic [KeyW-1:0] PressStop  = KeyW'(1 << KeyStop);
  localparam logic [KeyW-1:0] PressStart = KeyW'(1 << KeyStart);
  localparam logic [KeyW-1:0] PressAll   = '1;

  localparam readout_t Shows300 =
    '{13'd300, 4'd0, 4'd5, 3'd0, 4'd0, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam readout_t Shows900Long =
    '{13'd900, 4'd1, 4'd5, 3'd0, 4'd0, 1'b0, 1'b1, 1'b0, 1'b1};

  localparam int QuietLimit = 5000;
  localparam int PhaseItems = 262;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              req_type = 1'b0;
  logic [KeyW-1:0]   keys = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CountW-1:0] remaining;
  logic [3:0]        min_tens;
  logic [3:0]        min_units;
  logic [2:0]        sec_tens;
  logic [3:0]        sec_units;
  logic              running;
  logic              colon_on;
  logic              alarm;
  logic              long_selected;

  countdown_timer_with_keys_top u_top (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .keys          (keys),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .remaining     (remaining),
    .min_tens      (min_tens),
    .min_units     (min_units),
    .sec_tens      (sec_tens),
    .sec_units     (sec_units),
    .running       (running),
    .colon_on      (colon_on),
    .alarm         (alarm),
    .long_selected (long_selected)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Timer model: configuration and state
  logic [CountW-1:0] cfg_short, cfg_long;
  logic [TpsW-1:0]   cfg_tps;
  logic [DebW-1:0]   cfg_deb;
  logic [CountW-1:0] t_count;
  logic              t_long, t_run, t_alarm, t_colon, t_held;
  logic [TpsW-1:0]   t_phase;
  logic [DebW-1:0]   t_deb;
  logic [KeyW-1:0]   t_last;

  readout_t pending_readouts[$];
  int       mismatches = 0;
  int       quiet_cycles = 0;
  bit       calm = 1'b0;

  function automatic logic [CountW-1:0] selected_preset();
    return t_long ? cfg_long : cfg_short;
  endfunction

  task automatic stop_at_zero();
    if (t_count == '0) begin
      t_run = 1'b0;
      t_alarm = 1'b1;
    end
  endtask

  task automatic timer_tick();
    t_phase = t_phase + 1'b1;
    if (t_phase >= cfg_tps) begin
      if (t_run) begin
        if (t_count != '0) t_count = t_count - 1'b1;
        stop_at_zero();
        t_colon = 1'b1;
      end
      t_phase = '0;
    end
    if (t_phase == (cfg_tps >> 1) && t_run) t_colon = 1'b0;
    if (t_deb != '0) t_deb = t_deb - 1'b1;
  endtask

  task automatic timer_keys(input logic [KeyW-1:0] k);
    if (k != t_last) begin
      // a change restarts the debounce
      t_deb = cfg_deb;
      t_last = k;
    end else if (t_deb == '0) begin
      if (t_held) begin
        if (k == KeysNone) t_held = 1'b0;
      end else if (k != KeysNone) begin
        t_held = 1'b1;
        if (k[KeyReset]) begin
          if (!t_run) begin
            if (t_count != selected_preset()) begin
              t_count = selected_preset();
              t_alarm = 1'b0;
            end else begin
              t_long = ~t_long;
              t_count = selected_preset();
            end
            stop_at_zero();
          end
          t_colon = 1'b1;
        end else if (k[KeyStop]) begin
          if (t_run) begin
            t_run = 1'b0;
            stop_at_zero();
          end
        end else if (!t_run && t_count != '0) begin
          t_run = 1'b1;
        end
      end
    end
  endtask

  function automatic readout_t timer_readout();
    readout_t r;
    r.remaining     = t_count;
    r.min_tens      = 4'(t_count / 600);
    r.min_units     = 4'((t_count / 60) % 10);
    r.sec_tens      = 3'((t_count % 60) / 10);
    r.sec_units     = 4'(t_count % 10);
    r.running       = t_run;
    r.colon_on      = t_colon;
    r.alarm         = t_alarm;
    r.long_selected = t_long;
    return r;
  endfunction

  function automatic string describe(input readout_t r);
    return $sformatf("%0d (%0d%0d:%0d%0d) run=%0b colon=%0b alarm=%0b long=%0b",
                     r.remaining, r.min_tens, r.min_units, r.sec_tens, r.sec_units,
                     r.running, r.colon_on, r.alarm, r.long_selected);
  endfunction

  function automatic step_t item_step(input logic kind, input logic [KeyW-1:0] k,
                                      input logic typed = 1'b0,
                                      input readout_t want = '0);
    step_t s;
    s = '0;
    s.kind = kind;
    s.pressed = k;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic step_t write_step(input logic [RegIdxW-1:0] idx,
                                       input logic [PdataW-1:0] val);
    step_t s;
    s = '0;
    s.is_write = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  task automatic send_item(input logic kind, input logic [KeyW-1:0] k,
                           input logic typed = 1'b0, input readout_t want = '0);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    keys <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == ReqTick) timer_tick();
    else timer_keys(k);
    pending_readouts.push_back(typed ? want : timer_readout());
  endtask

  // Hold a key pattern through the debounce until it takes effect
  task automatic hold_keys(input logic [KeyW-1:0] k, inout int sent);
    send_item(ReqKeys, k);
    repeat (cfg_deb) send_item(ReqTick, KeyW'($urandom));
    send_item(ReqKeys, k);
    sent += 2 + cfg_deb;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [RegIdxW-1:0] idx, input logic [PdataW-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegPresetShort: cfg_short = val[CountW-1:0];
      RegPresetLong:  cfg_long = val[CountW-1:0];
      RegTicksPerSec: cfg_tps = val[TpsW-1:0];
      RegDebounce:    cfg_deb = val[DebW-1:0];
    endcase
  endtask

  task automatic random_phase(input int budget);
    int              sent;
    int              pick;
    logic [KeyW-1:0] k;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        repeat ($urandom_range(1, 2 * cfg_tps + 2)) begin
          send_item(ReqTick, KeyW'($urandom));
          sent++;
        end
      end else if (pick < 85) begin
        case ($urandom_range(0, 4))
          0:       k = PressReset;
          1:       k = PressStop;
          2, 3:    k = PressStart;
          default: k = KeyW'($urandom_range(1, 7));
        endcase
        hold_keys(k, sent);
        if ($urandom_range(0, 3) == 0) begin
          send_item(ReqKeys, k);
          sent++;
        end
        hold_keys(KeysNone, sent);
      end else begin
        // noise: random items that break the press sequences
        send_item(1'($urandom_range(0, 1)), KeyW'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    step_t      plan[$];
    timer_cfg_t settings[$];
    cfg_short = PresetShortRst;
    cfg_long  = PresetLongRst;
    cfg_tps   = TicksPerSecRst;
    cfg_deb   = DebounceRst;
    t_count   = PresetShortRst;
    t_long    = 1'b0;
    t_run     = 1'b0;
    t_alarm   = 1'b0;
    t_colon   = 1'b1;
    t_held    = 1'b0;
    t_phase   = '0;
    t_deb     = '0;
    t_last    = KeysNone;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    plan = '{
      item_step(ReqTick, PressAll, 1'b1, Shows300),
      item_step(ReqKeys, PressReset, 1'b1, Shows300),
      item_step(ReqTick, KeysNone, 1'b1, Shows300),
      item_step(ReqTick, PressStop, 1'b1, Shows300),
      item_step(ReqKeys, PressReset, 1'b1, Shows900Long),
      write_step(RegDebounce, 32'd0),
      write_step(RegPresetShort, 32'd2),
      write_step(RegTicksPerSec, 32'd2),
      item_step(ReqKeys, KeysNone),
      item_step(ReqKeys, KeysNone),
      item_step(ReqKeys, PressAll),
      item_step(ReqKeys, PressAll),
      item_step(ReqKeys, KeysNone),
      item_step(ReqKeys, KeysNone),
      item_step(ReqKeys, PressStart),
      item_step(ReqKeys, PressStart),
      item_step(ReqKeys, KeysNone),
      item_step(ReqKeys, KeysNone),
      item_step(ReqKeys, PressReset | PressStop),
      item_step(ReqKeys, PressReset | PressStop),
      item_step(ReqTick, KeysNone),
      item_step(ReqTick, PressStart),
      item_step(ReqTick, KeysNone),
      item_step(ReqTick, KeysNone),
      item_step(ReqKeys, KeysNone),
      item_step(ReqKeys, KeysNone),
      item_step(ReqKeys, PressStart),
      item_step(ReqKeys, PressStart),
      item_step(ReqKeys, KeysNone),
      item_step(ReqKeys, KeysNone),
      item_step(ReqKeys, PressReset),
      item_step(ReqKeys, PressReset)
    };
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        drain();
        reg_write(plan[i].idx, plan[i].val);
      end else begin
        send_item(plan[i].kind, plan[i].pressed, plan[i].typed, plan[i].want);
      end
    end

    // cover a zero preset, presets past 59:59 and tick rates below two
    settings = '{
      '{13'd1,    13'd5999, 4'd2,  2'd0},
      '{13'd5999, 13'd1,    4'd15, 2'd3},
      '{13'd3,    13'd7,    4'd3,  2'd1},
      '{13'd8191, 13'd0,    4'd1,  2'd0},
      '{13'd20,   13'd600,  4'd0,  2'd2}
    };
    settings.push_back('{CountW'($urandom_range(1, 40)), CountW'($urandom_range(1, 5999)),
                         TpsW'($urandom_range(2, 15)), DebW'($urandom_range(0, 3))});
    foreach (settings[p]) begin
      drain();
      reg_write(RegPresetShort, PdataW'(settings[p].short_preset));
      reg_write(RegPresetLong, PdataW'(settings[p].long_preset));
      reg_write(RegTicksPerSec, PdataW'(settings[p].tick_rate));
      reg_write(RegDebounce, PdataW'(settings[p].debounce));
      calm = (p == 2);
      random_phase(PhaseItems);
    end
    calm = 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("countdown_timer_with_keys_top regression: pass");
    end else begin
      $display("countdown_timer_with_keys_top regression: fail");
    end
    $finish;
  end

  // Result checker, result-side stall and watchdog
  always @(posedge clk) begin
    readout_t got;
    readout_t want;
    got = {remaining, min_tens, min_units, sec_tens, sec_units,
           running, colon_on, alarm, long_selected};
    if (!rst && out_valid && !out_stall) begin
      if (pending_readouts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(got));
      end else begin
        want = pending_readouts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected %s", describe(want));
            $display("                 actual   %s", describe(got));
          end
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles = 0;
    else quiet_cycles++;
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 31);
    if (quiet_cycles >= QuietLimit) begin
      $display("countdown_timer_with_keys_top regression: fail");
      $finish;
    end
  end

endmodule

/* files.f */
rtl/core/cdt_pkg.sv
rtl/core/countdown_timer_with_keys_top.sv
dv/countdown_timer_with_keys_top_test.sv
